// ===== sv/hcm_pkg.sv =====
// Package for the homography coordinate mapper.
// Holds the field widths, register indexes and the divider control record.
// Depends on nothing.
package hcm_pkg;

	localparam int CoefW = 32;
	localparam int CoordW = 12;
	localparam int OffW = 16;
	localparam int OutW = 32;
	localparam int CfgW = 64;
	localparam int IdxW = 3;
	localparam int PosW = 18;
	localparam int ProdW = CoefW + PosW;
	localparam int SumW = ProdW + 1;
	localparam int MagW = SumW;
	localparam int NumW = MagW + 10;
	localparam int DenW = SumW + 1;
	localparam int QuoW = 33;
	localparam int RemW = DenW + QuoW;
	localparam int DefMaxDim = 4096;
	localparam logic [CoefW-1:0] ScaleReset = 32'h0001_0000;

	localparam logic [IdxW-1:0] RegRow0 = 3'd0;
	localparam logic [IdxW-1:0] RegRow1 = 3'd1;
	localparam logic [IdxW-1:0] RegRow2 = 3'd2;
	localparam logic [IdxW-1:0] RegTrans = 3'd3;
	localparam logic [IdxW-1:0] RegScale = 3'd4;
	localparam logic [IdxW-1:0] RegXOff = 3'd5;
	localparam logic [IdxW-1:0] RegYOff = 3'd6;
	localparam logic [IdxW-1:0] RegDir = 3'd7;

	// Control that travels alongside the remainders through the divider.
	typedef struct packed {
		logic valid;
		logic forced;
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
	} div_ctl_t;

endpackage

// ===== sv/hcm_div_step.sv =====
// One restoring division step for both coordinates, with its pipeline register.
// Depends on hcm_pkg.
module hcm_div_step import hcm_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  div_ctl_t         ctl_in,
	input  logic [RemW-1:0]  rx_in,
	input  logic [RemW-1:0]  ry_in,
	input  logic [QuoW-1:0]  qx_in,
	input  logic [QuoW-1:0]  qy_in,
	input  logic [DenW-1:0]  d_in,
	output div_ctl_t         ctl_out,
	output logic [RemW-1:0]  rx_out,
	output logic [RemW-1:0]  ry_out,
	output logic [QuoW-1:0]  qx_out,
	output logic [QuoW-1:0]  qy_out,
	output logic [DenW-1:0]  d_out
);

	logic [RemW-1:0] dsh;
	logic            gx, gy;

	// Compare each remainder with the shifted divisor.
	always_comb begin
		dsh = RemW'(d_in) << SHIFT;
		gx = rx_in >= dsh;
		gy = ry_in >= dsh;
	end

	// Control resets; the data does not need to.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (adv) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_out <= gx ? rx_in - dsh : rx_in;
			ry_out <= gy ? ry_in - dsh : ry_in;
			qx_out <= qx_in | (QuoW'(gx) << SHIFT);
			qy_out <= qy_in | (QuoW'(gy) << SHIFT);
			d_out <= d_in;
		end
	end

endmodule

// ===== sv/homography_coordinate_mapper.sv =====
// Homography coordinate mapper, the top level.
// Maps each pixel coordinate through a configured 3x3 homography with divide.
// Depends on hcm_pkg and hcm_div_step.
//
// Items enter on in_valid/in_stall as col and row; each gives one transfer on
// out_valid/out_stall carrying mapped_x, mapped_y and invalid.
// Registers are written through cfg_we, cfg_index and cfg_data; a write takes
// effect at once. The user must write them only while the block is idle; the block does not check.
// Throughput is one item per cycle while no result is held by out_stall. An
// accepted transfer passes four stages that form the products, sums and
// dividend, 33 stages that each retire one quotient bit of the perspective divide,
// and one stage that applies sign, offset and saturation into the output register.
// The whole pipeline moves together: while a result is held by out_stall no
// stage advances and in_stall is raised, so nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values (h22 = 1.0).
module homography_coordinate_mapper import hcm_pkg::*; #(
	parameter int MAX_DIM = DefMaxDim
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CoordW-1:0]       col,
	input  logic [CoordW-1:0]       row,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OutW-1:0]  mapped_x,
	output logic signed [OutW-1:0]  mapped_y,
	output logic                    invalid,
	input  logic                    cfg_we,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [CfgW-1:0]         cfg_data
);

	localparam int DimW = 18;
	localparam logic [DimW-1:0] DimLimit = DimW'(MAX_DIM);
	localparam int Steps = QuoW;

	logic [CfgW-1:0]  row0_q, row1_q, row2_q, trans_q;
	logic [CoefW-1:0] scale_q;
	logic [OffW-1:0]  xoff_q, yoff_q;
	logic             dir_q;
	logic             adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
			trans_q <= '0;
			scale_q <= ScaleReset;
			xoff_q <= '0;
			yoff_q <= '0;
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRow0:  row0_q <= cfg_data;
				RegRow1:  row1_q <= cfg_data;
				RegRow2:  row2_q <= cfg_data;
				RegTrans: trans_q <= cfg_data;
				RegScale: scale_q <= cfg_data[CoefW-1:0];
				RegXOff:  xoff_q <= cfg_data[OffW-1:0];
				RegYOff:  yoff_q <= cfg_data[OffW-1:0];
				RegDir:   dir_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// The pipeline advances unless a finished result is being held.
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: range check and offset addition.
	logic                   valid_s1, bad_s1;
	logic signed [PosW-1:0] px_s1, py_s1;
	logic signed [PosW-1:0] xo_ext, yo_ext;
	assign xo_ext = PosW'(signed'(xoff_q));
	assign yo_ext = PosW'(signed'(yoff_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= (DimW'(col) >= DimLimit) || (DimW'(row) >= DimLimit);
			px_s1 <= signed'(PosW'(col)) + (dir_q ? '0 : xo_ext);
			py_s1 <= signed'(PosW'(row)) + (dir_q ? '0 : yo_ext);
		end
	end

	// Stage 2: the six products, the scaled translation terms and the scaled h22 term.
	logic                    valid_s2, bad_s2;
	logic signed [ProdW-1:0] p00_s2, p01_s2, p10_s2, p11_s2, p20_s2, p21_s2;
	logic signed [ProdW-1:0] t0_s2, t1_s2, t2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s2 <= bad_s1;
			p00_s2 <= ProdW'(signed'(row0_q[63:32])) * ProdW'(px_s1);
			p01_s2 <= ProdW'(signed'(row0_q[31:0])) * ProdW'(py_s1);
			p10_s2 <= ProdW'(signed'(row1_q[63:32])) * ProdW'(px_s1);
			p11_s2 <= ProdW'(signed'(row1_q[31:0])) * ProdW'(py_s1);
			p20_s2 <= ProdW'(signed'(row2_q[63:32])) * ProdW'(px_s1);
			p21_s2 <= ProdW'(signed'(row2_q[31:0])) * ProdW'(py_s1);
			t0_s2 <= ProdW'(signed'(trans_q[63:32])) <<< 12;
			t1_s2 <= ProdW'(signed'(trans_q[31:0])) <<< 12;
			t2_s2 <= ProdW'(signed'(scale_q)) <<< 12;
		end
	end

	// Stage 3: numerators and denominator in Q.28.
	logic                   valid_s3, bad_s3;
	logic signed [SumW-1:0] nx_s3, ny_s3, w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s3 <= bad_s2;
			nx_s3 <= SumW'(p00_s2) + SumW'(p01_s2) + SumW'(t0_s2);
			ny_s3 <= SumW'(p10_s2) + SumW'(p11_s2) + SumW'(t1_s2);
			w_s3 <= SumW'(p20_s2) + SumW'(p21_s2) + SumW'(t2_s2);
		end
	end

	// Stage 4: magnitudes, rounding dividends and the early overflow test.
	logic [MagW-1:0] magx, magy;
	logic [NumW-1:0] numx, numy;
	logic [DenW-1:0] den;
	logic [RemW-1:0] lim;
	div_ctl_t        ctl4;

	always_comb begin
		magx = nx_s3[SumW-1] ? MagW'(-nx_s3) : MagW'(nx_s3);
		magy = ny_s3[SumW-1] ? MagW'(-ny_s3) : MagW'(ny_s3);
		numx = (NumW'(magx) << 9) + NumW'(unsigned'(w_s3));
		numy = (NumW'(magy) << 9) + NumW'(unsigned'(w_s3));
		den = DenW'(unsigned'(w_s3)) << 1;
		lim = RemW'(den) << QuoW;
		ctl4.valid = valid_s3;
		ctl4.forced = bad_s3 || w_s3[SumW-1] || (w_s3 == '0);
		ctl4.ovf_x = RemW'(numx) >= lim;
		ctl4.ovf_y = RemW'(numy) >= lim;
		ctl4.neg_x = nx_s3[SumW-1];
		ctl4.neg_y = ny_s3[SumW-1];
	end

	div_ctl_t        ctl_s4;
	logic [RemW-1:0] rx_s4, ry_s4;
	logic [DenW-1:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s4 <= RemW'(numx);
			ry_s4 <= RemW'(numy);
			d_s4 <= den;
		end
	end

	// Divider: one quotient bit per stage, most significant first.
	div_ctl_t        ctl_d [Steps+1];
	logic [RemW-1:0] rx_d [Steps+1];
	logic [RemW-1:0] ry_d [Steps+1];
	logic [QuoW-1:0] qx_d [Steps+1];
	logic [QuoW-1:0] qy_d [Steps+1];
	logic [DenW-1:0] d_d [Steps+1];

	assign ctl_d[0] = ctl_s4;
	assign rx_d[0] = rx_s4;
	assign ry_d[0] = ry_s4;
	assign qx_d[0] = '0;
	assign qy_d[0] = '0;
	assign d_d[0] = d_s4;

	for (genvar i = 0; i < Steps; i++) begin : g_div
		hcm_div_step #(.SHIFT(Steps - 1 - i)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_d[i]),
			.rx_in   (rx_d[i]),
			.ry_in   (ry_d[i]),
			.qx_in   (qx_d[i]),
			.qy_in   (qy_d[i]),
			.d_in    (d_d[i]),
			.ctl_out (ctl_d[i+1]),
			.rx_out  (rx_d[i+1]),
			.ry_out  (ry_d[i+1]),
			.qx_out  (qx_d[i+1]),
			.qy_out  (qy_d[i+1]),
			.d_out   (d_d[i+1])
		);
	end

	// Final stage: sign, offset subtraction and saturation.
	localparam int FinW = QuoW + 3;
	localparam logic signed [FinW-1:0] SatHi = FinW'(33'sh0_7FFF_FFFF);
	localparam logic signed [FinW-1:0] SatLo = -FinW'(33'sh0_8000_0000);
	div_ctl_t               ctl_f;
	logic signed [FinW-1:0] vx, vy;
	logic                   hx, lx, hy, ly, sat_x, sat_y;
	logic [OutW-1:0]        ox, oy;

	always_comb begin
		ctl_f = ctl_d[Steps];
		vx = ctl_f.neg_x ? -signed'(FinW'(qx_d[Steps])) : signed'(FinW'(qx_d[Steps]));
		vy = ctl_f.neg_y ? -signed'(FinW'(qy_d[Steps])) : signed'(FinW'(qy_d[Steps]));
		if (dir_q) begin
			vx = vx - (FinW'(signed'(xoff_q)) <<< 8);
			vy = vy - (FinW'(signed'(yoff_q)) <<< 8);
		end
		hx = ctl_f.ovf_x ? !ctl_f.neg_x : (vx > SatHi);
		lx = ctl_f.ovf_x ? ctl_f.neg_x : (vx < SatLo);
		hy = ctl_f.ovf_y ? !ctl_f.neg_y : (vy > SatHi);
		ly = ctl_f.ovf_y ? ctl_f.neg_y : (vy < SatLo);
		sat_x = hx || lx;
		sat_y = hy || ly;
		ox = hx ? 32'h7FFF_FFFF : (lx ? 32'h8000_0000 : vx[OutW-1:0]);
		oy = hy ? 32'h7FFF_FFFF : (ly ? 32'h8000_0000 : vy[OutW-1:0]);
		if (ctl_f.forced) begin
			ox = '0;
			oy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mapped_x <= signed'(ox);
			mapped_y <= signed'(oy);
			invalid <= ctl_f.forced || sat_x || sat_y;
		end
	end

`ifndef SYNTHESIS
	// A held result freezes the first stage as well.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(valid_s1))
		else $error("first stage moved while the pipeline was held");

	// An accepted transfer always lands in the first stage.
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item did not enter the pipeline");

	// A forced result reports zero coordinates.
	a_forced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_f.valid && ctl_f.forced |=> invalid && mapped_x == '0 && mapped_y == '0)
		else $error("forced result not cleared");
`endif

endmodule
